### src/handheld_memory_bus_decoder_assert.svh
// assertion helpers for the bus decoder
`ifndef HANDHELD_MEMORY_BUS_DECODER_ASSERT_SVH
`define HANDHELD_MEMORY_BUS_DECODER_ASSERT_SVH

// same-cycle implication
`define HMBD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bus decoder check failed");

// next-cycle implication
`define HMBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bus decoder check failed");

`endif

### src/hmbd_pkg.sv
package hmbd_pkg;

  localparam int unsigned MEM_AW    = 16;
  // rom 32k, vram 8k, eram 8k, wram 8k, oam 256, hram 128
  localparam int unsigned MEM_DEPTH = 57728;

  localparam logic [2:0] CMD_RD_BYTE  = 3'd0;
  localparam logic [2:0] CMD_RD_SHORT = 3'd1;
  localparam logic [2:0] CMD_WR_BYTE  = 3'd2;
  localparam logic [2:0] CMD_WR_SHORT = 3'd3;
  localparam logic [2:0] CMD_LOAD_ROM = 3'd4;

  localparam logic [15:0] OAM_START  = 16'hFE00;
  localparam logic [15:0] GAP_START  = 16'hFEA0;
  localparam logic [15:0] IO_START   = 16'hFF00;
  localparam logic [15:0] HRAM_START = 16'hFF80;
  localparam logic [15:0] IE_ADDR    = 16'hFFFF;
  localparam logic [7:0]  GAP_BYTE   = 8'hFF;

  // physical layout of the shared memory
  localparam logic [2:0] PH_VRAM = 3'b100;
  localparam logic [2:0] PH_ERAM = 3'b101;
  localparam logic [3:0] PH_WRL  = 4'b1100;
  localparam logic [3:0] PH_WRH  = 4'b1101;
  localparam logic [7:0] PH_OAM  = 8'hE0;
  localparam logic [8:0] PH_HRAM = 9'h1C2;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic              mem_rd;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic              irq_we;
    logic [7:0]        rd_const;
    logic              io_hit;
    logic [6:0]        io_offset;
    logic              io_wr;
    logic [7:0]        io_wdata;
  } dec_t;

  typedef struct packed {
    logic       mem_rd;
    logic [7:0] rd_const;
    logic       io_hit;
    logic [6:0] io_offset;
    logic       io_wr;
    logic [7:0] io_wdata;
    logic       last;
  } pend_t;

endpackage

### src/hmbd_mem.sv
module hmbd_mem (
  input  logic               clk,
  input  hmbd_pkg::mem_req_t req,
  output logic [7:0]         rdata
);
  import hmbd_pkg::*;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata_r;

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata_r <= mem[req.addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### src/hmbd_dec.sv
module hmbd_dec (
  input  logic           [15:0] addr,
  input  logic                  is_write,
  input  logic           [7:0]  wbyte,
  input  logic           [7:0]  irq_val,
  output hmbd_pkg::dec_t        dec
);
  import hmbd_pkg::*;

  logic       mem_hit;
  logic [15:0] phys;

  always_comb begin
    mem_hit       = 1'b0;
    phys          = '0;
    dec           = '0;
    unique case (addr[15:12]) inside
      4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7: begin
        mem_hit = 1'b1;
        phys    = {1'b0, addr[14:0]};
      end
      4'h8, 4'h9: begin
        mem_hit = 1'b1;
        phys    = {PH_VRAM, addr[12:0]};
      end
      4'hA, 4'hB: begin
        mem_hit = 1'b1;
        phys    = {PH_ERAM, addr[12:0]};
      end
      4'hC, 4'hE: begin
        mem_hit = 1'b1;
        phys    = {PH_WRL, addr[11:0]};
      end
      4'hD: begin
        mem_hit = 1'b1;
        phys    = {PH_WRH, addr[11:0]};
      end
      default: begin
        if (addr < OAM_START) begin
          mem_hit = 1'b1;
          phys    = {PH_WRH, addr[11:0]};
        end else if (addr < GAP_START) begin
          mem_hit = 1'b1;
          phys    = {PH_OAM, addr[7:0]};
        end else if (addr < IO_START) begin
          dec.rd_const = is_write ? 8'h00 : GAP_BYTE;
        end else if (addr < HRAM_START) begin
          dec.io_hit    = 1'b1;
          dec.io_offset = addr[6:0];
          dec.io_wr     = is_write;
          dec.io_wdata  = is_write ? wbyte : 8'h00;
        end else if (addr != IE_ADDR) begin
          mem_hit = 1'b1;
          phys    = {PH_HRAM, addr[6:0]};
        end else begin
          dec.irq_we   = is_write;
          dec.rd_const = is_write ? 8'h00 : irq_val;
        end
      end
    endcase
    dec.mem_addr = phys;
    dec.mem_rd   = mem_hit & ~is_write;
    // rom is read-only from the bus
    dec.mem_we   = mem_hit & is_write & addr[15];
  end

endmodule

### src/handheld_memory_bus_decoder.sv
// Address map of an 8-bit handheld console on a 16-bit bus. All byte stores
// (both rom banks, video ram, external ram, both work ram banks with their
// echo mirrors, sprite attribute ram and high ram) sit in one single-port
// synchronous memory with a registered read; the interrupt-enable byte is a
// flop. A byte command sustains one request per cycle while the output is not
// stalled, a short command holds the input until its second byte issues (low
// byte at addr, high byte at addr+1, wrapping at 0xFFFF), and a rom load
// writes one byte with no result. Each byte yields one result; accesses to
// 0xFF00-0xFF7F come out as io requests with offset and write data. Memory
// contents are undefined until written; there is no clearing pass after reset.
module handheld_memory_bus_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_addr,
  input  logic [15:0] in_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_rdata,
  output logic        out_io_hit,
  output logic [6:0]  out_io_offset,
  output logic        out_io_wr,
  output logic [7:0]  out_io_wdata,
  output logic        out_last
);
  import hmbd_pkg::*;

  state_t      state_r, state_nxt;
  pend_t       pend_r, pend_nxt;
  logic [15:0] base_r;
  logic        wr_r;
  logic [7:0]  whi_r;
  logic [7:0]  irq_r;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_rdata_r;
  logic        out_io_hit_r, out_io_wr_r, out_last_r;
  logic [6:0]  out_io_offset_r;
  logic [7:0]  out_io_wdata_r;

  logic        accept, out_free, load_out;
  logic        issue0, issue1, is_load, in_rw, in_wr, in_short;
  logic [15:0] dec_addr;
  logic        dec_wr;
  logic [7:0]  dec_wbyte;
  dec_t        dec;
  mem_req_t    mem_req;
  logic [7:0]  mem_rdata;

  hmbd_dec u_dec (
    .addr     (dec_addr),
    .is_write (dec_wr),
    .wbyte    (dec_wbyte),
    .irq_val  (irq_r),
    .dec      (dec)
  );

  hmbd_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_comb begin
    in_rw    = 1'b0;
    in_wr    = 1'b0;
    in_short = 1'b0;
    case (in_cmd) inside
      CMD_RD_BYTE:  in_rw = 1'b1;
      CMD_RD_SHORT: begin
        in_rw    = 1'b1;
        in_short = 1'b1;
      end
      CMD_WR_BYTE: begin
        in_rw = 1'b1;
        in_wr = 1'b1;
      end
      CMD_WR_SHORT: begin
        in_rw    = 1'b1;
        in_wr    = 1'b1;
        in_short = 1'b1;
      end
      default: ;
    endcase
  end

  // control outputs
  always_comb begin
    out_free = ~out_valid_r | ~out_stall;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_RESP: in_stall = ~(pend_r.last & out_free);
      default: in_stall = 1'b1;
    endcase
    accept   = in_valid & ~in_stall;
    load_out = (state_r == ST_RESP) & out_free;
    issue1   = load_out & ~pend_r.last;
    issue0   = accept & in_rw;
    is_load  = accept & (in_cmd == CMD_LOAD_ROM);

    dec_addr  = issue1 ? base_r + 16'd1 : in_addr;
    dec_wr    = issue1 ? wr_r : in_wr;
    dec_wbyte = issue1 ? whi_r : in_wdata[7:0];

    mem_req = '0;
    if (is_load) begin
      mem_req.en    = 1'b1;
      mem_req.we    = 1'b1;
      mem_req.addr  = {1'b0, in_addr[14:0]};
      mem_req.wdata = in_wdata[7:0];
    end else if (issue0 | issue1) begin
      mem_req.en    = dec.mem_rd | dec.mem_we;
      mem_req.we    = dec.mem_we;
      mem_req.addr  = dec.mem_addr;
      mem_req.wdata = dec_wbyte;
    end

    pend_nxt.mem_rd    = dec.mem_rd;
    pend_nxt.rd_const  = dec.rd_const;
    pend_nxt.io_hit    = dec.io_hit;
    pend_nxt.io_offset = dec.io_offset;
    pend_nxt.io_wr     = dec.io_wr;
    pend_nxt.io_wdata  = dec.io_wdata;
    pend_nxt.last      = issue1 | ~in_short;

    out_valid_nxt = out_valid_r & out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (issue0) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (load_out & pend_r.last & ~issue0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      irq_r       <= 8'h00;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if ((issue0 | issue1) & dec.irq_we) begin
        irq_r <= dec_wbyte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue0 | issue1) begin
      pend_r <= pend_nxt;
    end
    if (issue0) begin
      base_r <= in_addr;
      wr_r   <= in_wr;
      whi_r  <= in_wdata[15:8];
    end
    if (load_out) begin
      out_rdata_r     <= pend_r.mem_rd ? mem_rdata : pend_r.rd_const;
      out_io_hit_r    <= pend_r.io_hit;
      out_io_offset_r <= pend_r.io_offset;
      out_io_wr_r     <= pend_r.io_wr;
      out_io_wdata_r  <= pend_r.io_wdata;
      out_last_r      <= pend_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rdata     = out_rdata_r;
  assign out_io_hit    = out_io_hit_r;
  assign out_io_offset = out_io_offset_r;
  assign out_io_wr     = out_io_wr_r;
  assign out_io_wdata  = out_io_wdata_r;
  assign out_last      = out_last_r;

`include "handheld_memory_bus_decoder_assert.svh"

  // the single memory port never serves both bytes at once
  `HMBD_ASSERT_NOW(a_single_issue, issue0, !issue1)
  // a short always produces a non-final first byte
  `HMBD_ASSERT_NEXT(a_short_first, issue0 && in_short, !pend_r.last && state_r == ST_RESP)
  // an io result never carries read data
  `HMBD_ASSERT_NOW(a_io_no_rdata, out_valid_r && out_io_hit_r, out_rdata_r == 8'h00)
  // delivering a first byte launches the second
  `HMBD_ASSERT_NOW(a_second_byte, load_out && !pend_r.last, issue1 && !in_stall == 1'b0)

endmodule
